[design/ldr_pkg.sv]
// Shared types, constants and lookup functions of the load current duty regulator.
package ldr_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned RATIO_W  = 16;
  localparam int unsigned LED_W    = 3;
  localparam int unsigned MODE_W   = 4;
  localparam int unsigned DBAND_W  = 10;
  localparam int unsigned STEP_W   = 8;
  localparam int unsigned TICK_W   = 10;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 10;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP     = 2'd2;

  // Mode codes.
  localparam logic [MODE_W-1:0] MODE_SCHED_1     = 4'd1;
  localparam logic [MODE_W-1:0] MODE_SCHED_2     = 4'd2;
  localparam logic [MODE_W-1:0] MODE_SCHED_3     = 4'd3;
  localparam logic [MODE_W-1:0] MODE_CONST_FIRST = 4'd4;
  localparam logic [MODE_W-1:0] MODE_CONST_LAST  = 4'd12;

  localparam logic [MODE_W-1:0]  MODE_RESET     = 4'd0;
  localparam logic [DBAND_W-1:0] DEADBAND_RESET = 10'd2;
  localparam logic [STEP_W-1:0]  STEP_RESET     = 8'd1;

  localparam logic [TICK_W-1:0] SCHED_LEN = 10'd600;

  localparam logic [RATIO_W-1:0] RATIO_OFF = 16'hFFFF;
  localparam logic [RATIO_W-1:0] TX_TARGET = 16'h4480;
  localparam logic [RATIO_W-1:0] RX_TARGET = 16'h0B50;
  localparam logic [RATIO_W-1:0] SB_TARGET = 16'h0B50;
  localparam logic [RATIO_W-1:0] TX_START  = 16'h1DFF;
  localparam logic [RATIO_W-1:0] RX_START  = 16'h2DFF;
  localparam logic [RATIO_W-1:0] SB_START  = 16'h32FF;

  localparam logic [LED_W-1:0] LED_DARK   = 3'd0;
  localparam logic [LED_W-1:0] LED_WHITE  = 3'd7;
  localparam logic [LED_W-1:0] LED_PURPLE = 3'd5;
  localparam logic [LED_W-1:0] LED_RED    = 3'd4;
  localparam logic [LED_W-1:0] LED_BLUE   = 3'd1;

  typedef enum logic [1:0] {
    ACT_OFF,
    ACT_REG,
    ACT_WRAP
  } ldr_action_t;

  // What the schedule decoder hands to the regulator for one word.
  typedef struct packed {
    ldr_action_t        action;
    logic [RATIO_W-1:0] target;
    logic [RATIO_W-1:0] start;
    logic [LED_W-1:0]   led;
    logic               phase_start;
  } ldr_sel_t;

  function automatic logic [RATIO_W-1:0] const_start(input logic [MODE_W-1:0] mode);
    logic [RATIO_W-1:0] v;
    case (mode)
      4'd4:    v = 16'h32FF;
      4'd5:    v = 16'h2DFF;
      4'd6:    v = 16'h225F;
      4'd7:    v = 16'h220F;
      4'd8:    v = 16'h225F;
      4'd9:    v = 16'h1FFF;
      4'd10:   v = 16'h1DFF;
      4'd11:   v = 16'h1A9F;
      4'd12:   v = 16'h1907;
      default: v = RATIO_OFF;
    endcase
    return v;
  endfunction

  function automatic logic [RATIO_W-1:0] const_target(input logic [MODE_W-1:0] mode);
    logic [RATIO_W-1:0] v;
    case (mode)
      4'd4:    v = 16'h04D0;
      4'd5:    v = 16'h0B50;
      4'd6:    v = 16'h1610;
      4'd7:    v = 16'h1FC0;
      4'd8:    v = 16'h3060;
      4'd9:    v = 16'h4300;
      4'd10:   v = 16'h5E00;
      4'd11:   v = 16'h7340;
      4'd12:   v = 16'h8C00;
      default: v = RATIO_OFF;
    endcase
    return v;
  endfunction

  function automatic logic [LED_W-1:0] const_led(input logic [MODE_W-1:0] mode);
    logic [LED_W-1:0] v;
    case (mode)
      4'd4, 4'd5, 4'd6:   v = LED_BLUE;
      4'd7, 4'd8, 4'd9:   v = LED_PURPLE;
      4'd10, 4'd11, 4'd12: v = LED_WHITE;
      default:            v = LED_DARK;
    endcase
    return v;
  endfunction

endpackage

[design/ldr_sched.sv]
// Schedule decoder: picks phase, target, start ratio and LED color for the current tick.
module ldr_sched (
  input  logic [ldr_pkg::MODE_W-1:0] mode,
  input  logic [ldr_pkg::TICK_W-1:0] tick_count,
  input  logic                       phase_start,
  output ldr_pkg::ldr_sel_t          sel,
  output logic [ldr_pkg::TICK_W-1:0] tick_nxt
);
  import ldr_pkg::*;

  logic [TICK_W-1:0] rx_begin;
  logic [TICK_W-1:0] sb_begin;
  logic [TICK_W-1:0] tick_inc;

  assign tick_inc = TICK_W'(tick_count + 10'd1);

  always_comb begin
    case (mode)
      MODE_SCHED_1: begin
        rx_begin = 10'd60;
        sb_begin = 10'd120;
      end
      MODE_SCHED_2: begin
        rx_begin = 10'd30;
        sb_begin = 10'd60;
      end
      default: begin
        rx_begin = 10'd30;
        sb_begin = 10'd300;
      end
    endcase
  end

  always_comb begin
    sel.action      = ACT_OFF;
    sel.target      = TX_TARGET;
    sel.start       = TX_START;
    sel.led         = LED_DARK;
    sel.phase_start = phase_start;
    tick_nxt        = tick_count;
    if (mode inside {[MODE_SCHED_1:MODE_SCHED_3]}) begin
      sel.action = ACT_REG;
      tick_nxt   = tick_inc;
      if (tick_count < rx_begin) begin
        sel.led = (mode == MODE_SCHED_1) ? LED_WHITE : LED_RED;
      end else if (tick_count < sb_begin) begin
        sel.target = RX_TARGET;
        sel.start  = RX_START;
        sel.led    = LED_PURPLE;
        if (tick_count == rx_begin) begin
          sel.phase_start = 1'b1;
        end
      end else if (tick_count < SCHED_LEN) begin
        sel.target = SB_TARGET;
        sel.start  = SB_START;
        sel.led    = LED_BLUE;
        if (tick_count == sb_begin) begin
          sel.phase_start = 1'b1;
        end
      end else begin
        sel.action = ACT_WRAP;
        tick_nxt   = '0;
      end
    end else if (mode inside {[MODE_CONST_FIRST:MODE_CONST_LAST]}) begin
      sel.action = ACT_REG;
      sel.target = const_target(mode);
      sel.start  = const_start(mode);
      sel.led    = const_led(mode);
    end
  end

endmodule

[design/ldr_regulate.sv]
// Ratio regulator: loads the start ratio or steps the ratio around the deadband.
module ldr_regulate (
  input  ldr_pkg::ldr_sel_t           sel,
  input  logic [ldr_pkg::SAMPLE_W-1:0] sample,
  input  logic [ldr_pkg::DBAND_W-1:0]  deadband,
  input  logic [ldr_pkg::STEP_W-1:0]   step,
  input  logic [ldr_pkg::RATIO_W-1:0]  ratio,
  input  logic                         phase_start,
  output logic [ldr_pkg::RATIO_W-1:0]  ratio_nxt,
  output logic                         phase_nxt
);
  import ldr_pkg::*;

  logic [RATIO_W:0]   upper;
  logic [RATIO_W-1:0] lower;
  logic [RATIO_W-1:0] dband_ext;
  logic [RATIO_W-1:0] step_ext;
  logic               above;
  logic               below;

  assign dband_ext = RATIO_W'(deadband);
  assign step_ext  = RATIO_W'(step);
  assign upper     = {1'b0, sel.target} + {1'b0, dband_ext};
  assign lower     = sel.target - dband_ext;
  assign above     = {1'b0, sample} > upper;
  // With the deadband above the target the lower bound is negative.
  assign below     = (sel.target >= dband_ext) && (sample < lower);

  always_comb begin
    ratio_nxt = ratio;
    phase_nxt = phase_start;
    case (sel.action)
      ACT_OFF: begin
        ratio_nxt = RATIO_OFF;
      end
      ACT_WRAP: begin
        phase_nxt = 1'b1;
      end
      ACT_REG: begin
        phase_nxt = 1'b0;
        if (sel.phase_start) begin
          ratio_nxt = sel.start;
        end else if (above) begin
          ratio_nxt = RATIO_W'(ratio + step_ext);
        end else if (below) begin
          ratio_nxt = RATIO_W'(ratio - step_ext);
        end
      end
      default: begin
        ratio_nxt = ratio;
      end
    endcase
  end

endmodule

[design/load_current_duty_regulator.sv]
// Top level of the load current duty regulator: registers, handshakes and datapath.
//
// One current-sample word goes in per tick and one result word (PWM ratio and
// LED color) comes out for each. The block is a two-register pipeline: an
// input register holds the accepted sample, and a single pass of logic (the
// schedule decoder, a 17-bit and a 16-bit compare, one 16-bit add or subtract)
// updates the tick counter, phase flag and ratio while writing the result
// register. It accepts a word in every cycle while in_stall is low; each word
// passes the input register, then the result register, and back-to-back words
// stream at one per cycle as long as the output side does not stall. When the
// output is stalled, one result waits in the output register and one sample
// waits in the input register before in_stall rises. Modes 1 to 3 run a
// 600-tick transmit, receive and standby schedule; modes 4 to 12 regulate to
// a fixed target; other modes force the ratio to 0xFFFF. Configuration writes
// take effect at once and are meant to happen only while no word is in flight.
module load_current_duty_regulator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ldr_pkg::SAMPLE_W-1:0]    in_current_sample,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ldr_pkg::RATIO_W-1:0]     out_pwm_ratio,
  output logic [ldr_pkg::LED_W-1:0]       out_led_rgb,
  input  logic                            cfg_we,
  input  logic [ldr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ldr_pkg::CFG_DAT_W-1:0]   cfg_wdata
);
  import ldr_pkg::*;

  // Configuration registers.
  logic [MODE_W-1:0]  mode_r;
  logic [DBAND_W-1:0] deadband_r;
  logic [STEP_W-1:0]  step_r;

  // Regulator state.
  logic [TICK_W-1:0]  tick_count_r;
  logic               phase_start_r;
  logic [RATIO_W-1:0] ratio_r;

  // Input register.
  logic                st_valid_r;
  logic [SAMPLE_W-1:0] st_sample_r;

  // Result register.
  logic               out_valid_r;
  logic [RATIO_W-1:0] out_ratio_r;
  logic [LED_W-1:0]   out_led_r;

  ldr_sel_t           sel;
  logic [TICK_W-1:0]  tick_nxt;
  logic [RATIO_W-1:0] ratio_nxt;
  logic               phase_nxt;
  logic               fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_RESET;
      deadband_r <= DEADBAND_RESET;
      step_r     <= STEP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE:     mode_r     <= cfg_wdata[MODE_W-1:0];
        CFG_DEADBAND: deadband_r <= cfg_wdata[DBAND_W-1:0];
        CFG_STEP:     step_r     <= cfg_wdata[STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The held sample is processed whenever the result register is free or
  // is being emptied in this cycle.
  assign fire     = st_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = st_valid_r && !fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r <= 1'b0;
    end else if (!in_stall) begin
      st_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      st_sample_r <= in_current_sample;
    end
  end

  ldr_sched u_sched (
    .mode        (mode_r),
    .tick_count  (tick_count_r),
    .phase_start (phase_start_r),
    .sel         (sel),
    .tick_nxt    (tick_nxt)
  );

  ldr_regulate u_regulate (
    .sel         (sel),
    .sample      (st_sample_r),
    .deadband    (deadband_r),
    .step        (step_r),
    .ratio       (ratio_r),
    .phase_start (phase_start_r),
    .ratio_nxt   (ratio_nxt),
    .phase_nxt   (phase_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_count_r  <= '0;
      phase_start_r <= 1'b1;
      ratio_r       <= RATIO_OFF;
    end else if (fire) begin
      tick_count_r  <= tick_nxt;
      phase_start_r <= phase_nxt;
      ratio_r       <= ratio_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_ratio_r <= ratio_nxt;
      out_led_r   <= sel.led;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pwm_ratio = out_ratio_r;
  assign out_led_rgb   = out_led_r;

`ifndef SYNTH
  a_tick_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tick_count_r <= SCHED_LEN)
    else $error("tick counter ran past the schedule length");

  a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (st_valid_r && out_valid_r && out_stall))
    else $error("input stalled without a blocked word");

  a_off_result: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && sel.action == ACT_OFF) |=>
      (out_pwm_ratio == RATIO_OFF && out_led_rgb == LED_DARK && ratio_r == RATIO_OFF))
    else $error("off mode did not force the load off");

  a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && sel.action == ACT_WRAP) |=>
      (tick_count_r == '0 && phase_start_r && ratio_r == $past(ratio_r)))
    else $error("schedule wrap did not clear the counter and hold the ratio");

  a_result_written: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("processed word produced no result");
`endif

endmodule
